@@ rtl/bmdc_pkg.sv @@
// shared types, constants and register codes of the block median distance classifier
package bmdc_pkg;

  localparam int WINDOW_DEF      = 15;
  localparam int CHANNELS_DEF    = 2;
  localparam int SAMPLE_BITS_DEF = 16;

  localparam int DIST_W    = 16;
  localparam int LIMIT_W   = 16;
  localparam int LEVEL_W   = 2;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_LOW_LIMIT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NEAR_LIMIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FAR_LIMIT  = 2'd2;

  localparam logic [LIMIT_W-1:0] LOW_LIMIT_RESET  = 16'd160;
  localparam logic [LIMIT_W-1:0] NEAR_LIMIT_RESET = 16'd640;
  localparam logic [LIMIT_W-1:0] FAR_LIMIT_RESET  = 16'd1600;

  localparam logic [LEVEL_W-1:0] LEVEL_FAR    = 2'd0;
  localparam logic [LEVEL_W-1:0] LEVEL_MEDIUM = 2'd1;
  localparam logic [LEVEL_W-1:0] LEVEL_NEAR   = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_WAIT,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic clear;
    logic insert;
  } sort_ctl_t;

endpackage

@@ rtl/bmdc_store.sv @@
// sample store: one write port, one read port with registered read data
module bmdc_store #(
  parameter int DATA_W = 16,
  parameter int ADDR_W = 5
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ rtl/bmdc_sorter.sv @@
// insertion sorter that keeps the smallest samples of a window in ascending order
module bmdc_sorter
  import bmdc_pkg::*;
#(
  parameter int DATA_W = 16,
  parameter int KEEP   = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  sort_ctl_t         ctl,
  input  logic [DATA_W-1:0] data_in,
  output logic [DATA_W-1:0] median
);

  logic [DATA_W-1:0] cells      [KEEP];
  logic [DATA_W-1:0] cells_next [KEEP];
  logic [KEEP-1:0]   valid;
  logic [KEEP-1:0]   valid_next;
  logic [KEEP-1:0]   above;

  always_comb begin
    for (int k = 0; k < KEEP; k++) begin
      above[k] = !valid[k] || (cells[k] > data_in);
    end
    for (int k = 0; k < KEEP; k++) begin
      if (k == 0) begin
        cells_next[k] = above[k] ? data_in : cells[k];
        valid_next[k] = 1'b1;
      end else begin
        cells_next[k] = above[k] ? (above[k-1] ? cells[k-1] : data_in) : cells[k];
        valid_next[k] = valid[k] | valid[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.insert) begin
      for (int k = 0; k < KEEP; k++) begin
        cells[k] <= cells_next[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      valid <= '0;
    end else if (ctl.insert) begin
      valid <= valid_next;
    end
  end

  assign median = cells[KEEP-1];

endmodule

@@ rtl/block_median_distance_classifier_unit.sv @@
// top level of the block median distance classifier
//
// Each channel gathers WINDOW distance samples in the sample store. A sample that
// arrives for a channel with a full window starts a median pass: the window is read
// from the store one entry per cycle into an insertion sorter, the middle element is
// taken as the median, the channel's power level is updated when it exceeds the low limit
// and one result transaction is offered. The new sample then becomes the first entry of
// the next window. A sample that only fills the window is taken at once while no median
// pass runs; a sample that arrives for a full window holds the input through the read,
// wait and finish states, since the store has one read port. The result sits in an
// output register, so a pending result does not block new samples; only the next median
// pass waits for it. The store needs no clearing after reset.
module block_median_distance_classifier_unit
  import bmdc_pkg::*;
#(
  parameter int WINDOW      = WINDOW_DEF,
  parameter int CHANNELS    = CHANNELS_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [LIMIT_W-1:0]   cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 channel,
  input  logic [DIST_W-1:0]    distance,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_channel,
  output logic [DIST_W-1:0]    median,
  output logic [LEVEL_W-1:0]   power_level,
  output logic                 power_updated
);

  localparam int IDX_W  = $clog2(WINDOW);
  localparam int CNT_W  = $clog2(WINDOW + 1);
  localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int ADDR_W = CH_W + IDX_W;
  localparam int KEEP   = WINDOW / 2 + 1;
  localparam int CMP_W  = (SAMPLE_BITS > DIST_W) ? SAMPLE_BITS : DIST_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WINDOW - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(WINDOW);

  state_t state, state_next;

  logic [CNT_W-1:0]       fill_count [CHANNELS];
  logic [LEVEL_W-1:0]     held_power [CHANNELS];
  logic [LIMIT_W-1:0]     low_limit;
  logic [LIMIT_W-1:0]     near_limit;
  logic [LIMIT_W-1:0]     far_limit;
  logic [CH_W-1:0]        cur_ch;
  logic [SAMPLE_BITS-1:0] cur_sample;
  logic [IDX_W-1:0]       rd_idx;
  logic                   rd_pending;

  logic                   in_accept;
  logic [CH_W-1:0]        in_ch;
  logic                   ch_ok;
  logic [SAMPLE_BITS-1:0] in_sample;
  logic [CNT_W-1:0]       in_fill;
  logic                   window_full;
  logic                   start;
  logic                   store_now;
  logic                   out_free;
  logic                   finish_go;

  logic                   wr_en;
  logic [ADDR_W-1:0]      wr_addr;
  logic [SAMPLE_BITS-1:0] wr_data;
  logic                   rd_en;
  logic [ADDR_W-1:0]      rd_addr;
  logic [SAMPLE_BITS-1:0] rd_data;
  sort_ctl_t              sort_ctl;
  logic [SAMPLE_BITS-1:0] sort_median;

  logic [CMP_W-1:0]       med_ext;
  logic                   upd;
  logic [LEVEL_W-1:0]     level_new;

  assign cfg_ready   = 1'b1;
  assign in_accept   = in_valid && !in_stall;
  assign in_ch       = CH_W'(channel);
  assign ch_ok       = (32'(channel) < CHANNELS);
  assign in_sample   = SAMPLE_BITS'(CMP_W'(distance));
  assign in_fill     = fill_count[in_ch];
  assign window_full = (in_fill >= FULL_CNT);
  assign start       = in_accept && ch_ok && window_full;
  assign store_now   = in_accept && ch_ok && !window_full;
  assign out_free    = !out_valid || !out_stall;
  assign finish_go   = (state == S_FINISH) && out_free;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (start) state_next = S_READ;
      S_READ:   if (rd_idx == LAST_IDX) state_next = S_WAIT;
      S_WAIT:   state_next = S_FINISH;
      S_FINISH: if (out_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_stall        = (state != S_IDLE);
    rd_en           = (state == S_READ);
    rd_addr         = {cur_ch, rd_idx};
    wr_en           = store_now || finish_go;
    wr_addr         = finish_go ? {cur_ch, IDX_W'(0)} : {in_ch, in_fill[IDX_W-1:0]};
    wr_data         = finish_go ? cur_sample : in_sample;
    sort_ctl.clear  = start;
    sort_ctl.insert = rd_pending;
  end

  always_comb begin
    med_ext = CMP_W'(sort_median);
    upd     = med_ext > CMP_W'(low_limit);
    priority if (med_ext < CMP_W'(near_limit)) begin
      level_new = LEVEL_NEAR;
    end else if (med_ext < CMP_W'(far_limit)) begin
      level_new = LEVEL_MEDIUM;
    end else begin
      level_new = LEVEL_FAR;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      rd_pending <= 1'b0;
    end else begin
      state      <= state_next;
      rd_pending <= (state == S_READ);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rd_idx <= '0;
    end else if (state == S_READ) begin
      rd_idx <= rd_idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cur_ch     <= in_ch;
      cur_sample <= in_sample;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        fill_count[i] <= '0;
        held_power[i] <= LEVEL_FAR;
      end
    end else begin
      if (store_now) begin
        fill_count[in_ch] <= in_fill + 1'b1;
      end
      if (finish_go) begin
        fill_count[cur_ch] <= CNT_W'(1);
        if (upd) begin
          held_power[cur_ch] <= level_new;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      low_limit  <= LOW_LIMIT_RESET;
      near_limit <= NEAR_LIMIT_RESET;
      far_limit  <= FAR_LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_LOW_LIMIT:  low_limit  <= cfg_data;
        REG_NEAR_LIMIT: near_limit <= cfg_data;
        REG_FAR_LIMIT:  far_limit  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish_go) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish_go) begin
      out_channel   <= cur_ch[0];
      median        <= DIST_W'(med_ext);
      power_level   <= upd ? level_new : held_power[cur_ch];
      power_updated <= upd;
    end
  end

  bmdc_store #(
    .DATA_W (SAMPLE_BITS),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  bmdc_sorter #(
    .DATA_W (SAMPLE_BITS),
    .KEEP   (KEEP)
  ) u_sorter (
    .clk     (clk),
    .rst     (rst),
    .ctl     (sort_ctl),
    .data_in (rd_data),
    .median  (sort_median)
  );

endmodule

@@ rtl/bmdc_checker.sv @@
// port-level checks of the block median distance classifier and their binding
module bmdc_checker
  import bmdc_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic               out_channel,
  input logic [DIST_W-1:0]  median,
  input logic [LEVEL_W-1:0] power_level,
  input logic               power_updated
);

  logic [LEVEL_W-1:0] last_level [2];

  always_ff @(posedge clk) begin
    if (rst) begin
      last_level[0] <= LEVEL_FAR;
      last_level[1] <= LEVEL_FAR;
    end else if (out_valid && !out_stall) begin
      last_level[out_channel] <= power_level;
    end
  end

  // stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(median) && $stable(power_level))
    else $error("result changed while stalled");

  // level not recomputed keeps the channel's previous level
  a_level_held: assert property (@(posedge clk) disable iff (rst)
    out_valid && !power_updated |-> power_level == last_level[out_channel])
    else $error("held power level changed without update");

  // new result only comes out of a median pass, which holds off the input
  a_result_after_pass: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result without a median pass");

  // recomputed level is a legal code
  a_level_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && power_updated |-> power_level != 2'd3)
    else $error("illegal power level");

endmodule

bind block_median_distance_classifier_unit bmdc_checker u_bmdc_checker (
  .clk           (clk),
  .rst           (rst),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_channel   (out_channel),
  .median        (median),
  .power_level   (power_level),
  .power_updated (power_updated)
);

@@ verif/tb.sv @@
// self-checking testbench of the block median distance classifier unit
module tb;
  import bmdc_pkg::*;

  localparam int WIN = WINDOW_DEF;
  localparam int NCH = CHANNELS_DEF;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  localparam int SETTLE_CYCLES = 2 * WINDOW_DEF + 6;
  localparam int QUIET_LIMIT = 2000;

  typedef struct packed {
    logic               ch;
    logic [DIST_W-1:0]  med;
    logic [LEVEL_W-1:0] level;
    logic               updated;
  } median_result_t;

  logic                 clk;
  logic                 rst;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [LIMIT_W-1:0]   cfg_data;
  logic                 in_valid;
  logic                 in_stall;
  logic                 channel;
  logic [DIST_W-1:0]    distance;
  logic                 out_valid;
  logic                 out_stall;
  logic                 out_channel;
  logic [DIST_W-1:0]    median;
  logic [LEVEL_W-1:0]   power_level;
  logic                 power_updated;

  // predicted state of the block
  logic [DIST_W-1:0]  win_store [NCH][WIN];
  int                 win_fill [NCH];
  logic [LEVEL_W-1:0] level_held [NCH];
  logic [LIMIT_W-1:0] lim_low;
  logic [LIMIT_W-1:0] lim_near;
  logic [LIMIT_W-1:0] lim_far;
  median_result_t     pending_results [$];

  logic [DIST_W-1:0] target [NCH];
  bit gapless;
  int mismatches;
  int samples_sent;
  int medians_seen;
  int level_updates;
  int limit_sets;
  int quiet_cycles;

  block_median_distance_classifier_unit dut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .channel(channel),
    .distance(distance),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_channel(out_channel),
    .median(median),
    .power_level(power_level),
    .power_updated(power_updated)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch: %s", msg);
    mismatches++;
  endtask

  function automatic logic [DIST_W-1:0] middle_of_window(input int ch);
    int less;
    int leq;
    logic [DIST_W-1:0] pick;
    pick = '0;
    for (int k = 0; k < WIN; k++) begin
      less = 0;
      leq = 0;
      for (int j = 0; j < WIN; j++) begin
        if (win_store[ch][j] < win_store[ch][k]) less++;
        if (win_store[ch][j] <= win_store[ch][k]) leq++;
      end
      if (less <= WIN / 2 && leq > WIN / 2) pick = win_store[ch][k];
    end
    return pick;
  endfunction

  task automatic predict_sample(input logic ch, input logic [DIST_W-1:0] d);
    median_result_t r;
    if (win_fill[ch] < WIN) begin
      win_store[ch][win_fill[ch]] = d;
      win_fill[ch]++;
    end else begin
      r.ch = ch;
      r.med = middle_of_window(int'(ch));
      win_store[ch][0] = d;
      win_fill[ch] = 1;
      r.updated = (r.med > lim_low);
      if (r.updated) begin
        if (r.med < lim_near) level_held[ch] = LEVEL_NEAR;
        else if (r.med < lim_far) level_held[ch] = LEVEL_MEDIUM;
        else level_held[ch] = LEVEL_FAR;
      end
      r.level = level_held[ch];
      pending_results.push_back(r);
    end
  endtask

  task automatic check_median();
    median_result_t want;
    if (pending_results.size() == 0) begin
      report_mismatch($sformatf("result on channel %0d median %0h with nothing pending",
                                out_channel, median));
      return;
    end
    want = pending_results.pop_front();
    medians_seen++;
    if (want.updated) level_updates++;
    if (out_channel !== want.ch)
      report_mismatch($sformatf("out_channel got %0h expected %0h", out_channel, want.ch));
    if (median !== want.med)
      report_mismatch($sformatf("median got %0h expected %0h", median, want.med));
    if (power_level !== want.level)
      report_mismatch($sformatf("power_level got %0h expected %0h (median %0h)",
                                power_level, want.level, want.med));
    if (power_updated !== want.updated)
      report_mismatch($sformatf("power_updated got %0h expected %0h (median %0h)",
                                power_updated, want.updated, want.med));
  endtask

  always @(posedge clk) begin
    if (!rst && cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_LOW_LIMIT:  lim_low = cfg_data;
        REG_NEAR_LIMIT: lim_near = cfg_data;
        REG_FAR_LIMIT:  lim_far = cfg_data;
        default: ;
      endcase
    end
    if (!rst && in_valid && !in_stall) begin
      predict_sample(channel, distance);
      samples_sent++;
    end
    if (!rst && out_valid && !out_stall) check_median();
    if (!rst && ((cfg_valid && cfg_ready) || (in_valid && !in_stall) ||
                 (out_valid && !out_stall)))
      quiet_cycles = 0;
    else
      quiet_cycles++;
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(negedge clk);
    $display("timeout after %0d cycles with no transaction", QUIET_LIMIT);
    $display("[block_median_distance_classifier_unit] ERROR");
    $finish;
  end

  // result side backpressure
  initial begin
    int k;
    out_stall = 1'b0;
    wait (rst === 1'b0);
    forever begin
      k = gapless ? 0 : $urandom_range(0, 9);
      @(negedge clk);
      if (k > 0) begin
        out_stall <= 1'b1;
        repeat (k) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1);
    end
  end

  task automatic send_sample(input logic ch, input logic [DIST_W-1:0] d);
    int gap;
    gap = gapless ? 0 : $urandom_range(0, 9);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    channel <= ch;
    distance <= d;
    do @(posedge clk); while (in_stall !== 1'b0);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [LIMIT_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
  endtask

  task automatic set_limits(input logic [LIMIT_W-1:0] low, input logic [LIMIT_W-1:0] near,
                            input logic [LIMIT_W-1:0] far);
    wait_drained();
    write_reg(REG_SPARE, LIMIT_W'($urandom_range(0, 65535)));
    write_reg(REG_LOW_LIMIT, low);
    write_reg(REG_NEAR_LIMIT, near);
    write_reg(REG_FAR_LIMIT, far);
    @(negedge clk);
    cfg_valid <= 1'b0;
    limit_sets++;
  endtask

  function automatic logic [DIST_W-1:0] pick_target();
    logic [DIST_W-1:0] off;
    off = DIST_W'($urandom_range(0, 2));
    case ($urandom_range(0, 5))
      0: return lim_low + off - 16'd1;
      1: return lim_near + off - 16'd1;
      2: return lim_far + off - 16'd1;
      3: return DIST_W'($urandom_range(0, 65535));
      4: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      default: return DIST_W'($urandom_range(0, 2000));
    endcase
  endfunction

  function automatic logic [DIST_W-1:0] draw_distance(input int ch);
    logic [DIST_W-1:0] jitter;
    jitter = DIST_W'($urandom_range(0, 6));
    case ($urandom_range(0, 9))
      6, 7: return DIST_W'($urandom_range(0, 65535));
      8, 9: return target[ch] + jitter - 16'd3;
      default: return target[ch];
    endcase
  endfunction

  // windows cluster around a per-window value so medians can land on or near the limits
  task automatic run_random_windows(input int count);
    int ch;
    for (int i = 0; i < count; i++) begin
      ch = $urandom_range(0, NCH - 1);
      if (win_fill[ch] == 0 || win_fill[ch] == WIN) target[ch] = pick_target();
      send_sample(1'(ch), draw_distance(ch));
    end
  endtask

  task automatic test_extreme_samples();
    logic [DIST_W-1:0] extremes [WIN];
    extremes = '{16'h0000, 16'hFFFF, 16'h5555, 16'hAAAA, 16'h0001, 16'h8000, 16'h7FFF,
                 16'd160, 16'd161, 16'd640, 16'd639, 16'd1600, 16'd1599, 16'h0000,
                 16'hFFFF};
    for (int i = 0; i < WIN; i++) begin
      send_sample(1'b0, extremes[i]);
      if (i % 2 == 1) send_sample(1'b1, ~extremes[i]);
    end
    send_sample(1'b0, 16'h00FF);
  endtask

  task automatic test_reset_limits();
    run_random_windows(180);
  endtask

  task automatic test_limit_extremes();
    set_limits(16'h0000, 16'h0000, 16'h0000);
    run_random_windows(170);
    set_limits(16'hFFFF, 16'hFFFF, 16'hFFFF);
    run_random_windows(170);
    set_limits(16'h0000, 16'hFFFF, 16'hFFFF);
    run_random_windows(170);
  endtask

  task automatic test_unordered_limits();
    set_limits(16'd5000, 16'd1000, 16'd300);
    run_random_windows(170);
    set_limits(16'd300, 16'd30000, 16'd10000);
    run_random_windows(170);
  endtask

  task automatic test_random_limits();
    for (int i = 0; i < 3; i++) begin
      set_limits(LIMIT_W'($urandom_range(0, 4000)), LIMIT_W'($urandom_range(0, 20000)),
                 LIMIT_W'($urandom_range(0, 65535)));
      run_random_windows(100);
    end
  endtask

  task automatic test_back_to_back();
    set_limits(LOW_LIMIT_RESET, NEAR_LIMIT_RESET, FAR_LIMIT_RESET);
    gapless = 1'b1;
    run_random_windows(100);
    gapless = 1'b0;
  endtask

  initial begin
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = REG_LOW_LIMIT;
    cfg_data = '0;
    in_valid = 1'b0;
    channel = 1'b0;
    distance = '0;
    gapless = 1'b0;
    mismatches = 0;
    samples_sent = 0;
    medians_seen = 0;
    level_updates = 0;
    limit_sets = 1;
    quiet_cycles = 0;
    lim_low = LOW_LIMIT_RESET;
    lim_near = NEAR_LIMIT_RESET;
    lim_far = FAR_LIMIT_RESET;
    for (int c = 0; c < NCH; c++) begin
      win_fill[c] = 0;
      level_held[c] = LEVEL_FAR;
      target[c] = '0;
    end
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    test_extreme_samples();
    test_reset_limits();
    test_limit_extremes();
    test_unordered_limits();
    test_random_limits();
    test_back_to_back();
    wait_drained();
    $display("covered %0d samples on %0d channels, %0d medians checked", samples_sent, NCH,
             medians_seen);
    $display("%0d medians recomputed the level, across %0d threshold settings",
             level_updates, limit_sets);
    if (mismatches == 0)
      $display("[block_median_distance_classifier_unit] OK");
    else
      $display("[block_median_distance_classifier_unit] ERROR");
    $finish;
  end

endmodule
